### hw/rtl/html_entity_decoder_top_assert.svh
`ifndef HTML_ENTITY_DECODER_TOP_ASSERT_SVH
`define HTML_ENTITY_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define HED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// next-cycle implication
`define HED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

### hw/rtl/hed_pkg.sv
package hed_pkg;

    localparam int PEND_MAX = 16;
    localparam int ADDR_W   = $clog2(PEND_MAX);
    localparam int CNT_W    = $clog2(PEND_MAX + 1);
    localparam int NUM_ENT  = 6;
    localparam int CODE_W   = 9;
    localparam int SUM_W    = CODE_W + 4;

    localparam logic [CODE_W-1:0] CODE_SAT = 9'h100;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_AMP  = 3'd1,
        MODE_NAME = 3'd2,
        MODE_HASH = 3'd3,
        MODE_NUM  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_EMIT = 2'd1,
        STEP_FAIL = 2'd2
    } step_t;

    typedef struct packed {
        logic commit;
        logic capture_pend;
        logic flush_start;
        logic flush_last;
        logic flush_emit;
        logic flush_clear;
    } hed_cmd_t;

    typedef struct packed {
        step_t step;
        logic  last;
        logic  slot_free;
        logic  flush_final;
    } hed_stat_t;

    function automatic logic [2:0] ent_len(input logic [2:0] e);
        logic [2:0] r;
        case (e)
            3'd0:    r = 3'd6;
            3'd1:    r = 3'd5;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd6;
            3'd5:    r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_val(input logic [2:0] e);
        logic [7:0] r;
        case (e)
            3'd0:    r = 8'h20;
            3'd1:    r = 8'h26;
            3'd2:    r = 8'h3C;
            3'd3:    r = 8'h3E;
            3'd4:    r = 8'h22;
            3'd5:    r = 8'h27;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] e, input logic [2:0] pos);
        logic [47:0] s;
        logic [7:0]  c;
        case (e)
            3'd0:    s = "&nbsp;";
            3'd1:    s = {"&amp;", 8'h00};
            3'd2:    s = {"&lt;", 16'h0000};
            3'd3:    s = {"&gt;", 16'h0000};
            3'd4:    s = "&quot;";
            3'd5:    s = "&apos;";
            default: s = '0;
        endcase
        case (pos)
            3'd0:    c = s[47:40];
            3'd1:    c = s[39:32];
            3'd2:    c = s[31:24];
            3'd3:    c = s[23:16];
            3'd4:    c = s[15:8];
            3'd5:    c = s[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
        logic [7:0] t;
        logic [4:0] r;
        t = '0;
        r = '0;
        if (b >= CH_0 && b <= CH_9)
        begin
            t = b - CH_0;
            r = {1'b1, t[3:0]};
        end
        else if (hex && b >= CH_LA && b <= CH_LF)
        begin
            t = b - CH_LA + 8'd10;
            r = {1'b1, t[3:0]};
        end
        else if (hex && b >= CH_UA && b <= CH_UF)
        begin
            t = b - CH_UA + 8'd10;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage

### hw/rtl/hed_ram.sv
module hed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/hed_datapath.sv
module hed_datapath import hed_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic [7:0] in_byte,
    input  logic      in_last,
    input  logic      out_stall,
    input  hed_cmd_t  cmd,
    output hed_stat_t stat,
    output logic      out_valid,
    output logic [7:0] out_byte,
    output logic      out_last
);

    logic [CNT_W-1:0]   count_reg, count_next;
    mode_t              mode_reg, mode_next;
    logic               hex_reg, hex_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [NUM_ENT-1:0] alive_reg, alive_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               flush_last_reg, flush_last_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic [7:0]         pend_byte_reg, pend_byte_next;
    logic               pend_last_reg, pend_last_next;

    logic [7:0]         src_byte;
    logic               src_last;
    logic               text_path;
    step_t              step;
    logic [7:0]         dec;
    mode_t              mode_n;
    logic               hex_n;
    logic [CODE_W-1:0]  code_n;
    logic [NUM_ENT-1:0] alive_n;
    logic [NUM_ENT-1:0] hit;
    logic               name_done;
    logic [7:0]         name_val;
    logic [4:0]         dig_dec;
    logic [4:0]         dig_cur;
    logic [SUM_W-1:0]   code_mul;
    logic [SUM_W-1:0]   code_sum;
    logic [CODE_W-1:0]  code_sat;
    logic [7:0]         num_dec;
    logic               slot_free;
    logic               flush_final;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_rdata;

    assign src_byte    = pend_valid_reg ? pend_byte_reg : in_byte;
    assign src_last    = pend_valid_reg ? pend_last_reg : in_last;
    assign text_path   = (mode_reg == MODE_TEXT) || (count_reg == '0);
    assign slot_free   = !out_valid_reg || !out_stall;
    assign flush_final = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    // entity prefix match against the held name
    always_comb
    begin
        hit       = '0;
        name_done = 1'b0;
        name_val  = '0;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            hit[e] = alive_reg[e]
                && (count_reg < CNT_W'(ent_len(3'(e))))
                && (ent_char(3'(e), count_reg[2:0]) == src_byte);
        end
        for (int e = NUM_ENT - 1; e >= 0; e--)
        begin
            if (hit[e])
            begin
                name_done = (count_reg + CNT_W'(1)) == CNT_W'(ent_len(3'(e)));
                name_val  = ent_val(3'(e));
            end
        end
    end

    // numeric accumulator
    always_comb
    begin
        dig_dec  = digit_of(src_byte, 1'b0);
        dig_cur  = digit_of(src_byte, hex_reg);
        code_mul = hex_reg ? {code_reg, 4'b0000}
                           : (SUM_W'({code_reg, 3'b000}) + SUM_W'({code_reg, 1'b0}));
        code_sum = code_mul + SUM_W'(dig_cur[3:0]);
        code_sat = (code_sum > SUM_W'(CODE_SAT)) ? CODE_SAT : code_sum[CODE_W-1:0];
        num_dec  = (code_reg != '0 && !code_reg[CODE_W-1]) ? code_reg[7:0] : CH_QMARK;
    end

    // step decision for one byte
    always_comb
    begin
        step    = STEP_FAIL;
        dec     = src_byte;
        mode_n  = mode_reg;
        hex_n   = hex_reg;
        code_n  = code_reg;
        alive_n = alive_reg;
        if (text_path)
        begin
            if (src_byte == CH_AMP)
            begin
                step    = STEP_HOLD;
                mode_n  = MODE_AMP;
                hex_n   = 1'b0;
                code_n  = '0;
                alive_n = '1;
            end
            else
            begin
                step = STEP_EMIT;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_AMP, MODE_NAME:
                begin
                    if (mode_reg == MODE_AMP && src_byte == CH_HASH)
                    begin
                        step   = STEP_HOLD;
                        mode_n = MODE_HASH;
                    end
                    else if (|hit)
                    begin
                        mode_n = MODE_NAME;
                        if (name_done)
                        begin
                            step = STEP_EMIT;
                            dec  = name_val;
                        end
                        else
                        begin
                            step    = STEP_HOLD;
                            alive_n = hit;
                        end
                    end
                end
                MODE_HASH:
                begin
                    if (src_byte == CH_LX || src_byte == CH_UX)
                    begin
                        step   = STEP_HOLD;
                        mode_n = MODE_NUM;
                        hex_n  = 1'b1;
                        code_n = '0;
                    end
                    else if (src_byte == CH_SEMI)
                    begin
                        step = STEP_EMIT;
                        dec  = CH_QMARK;
                    end
                    else if (dig_dec[4])
                    begin
                        step   = STEP_HOLD;
                        mode_n = MODE_NUM;
                        hex_n  = 1'b0;
                        code_n = CODE_W'(dig_dec[3:0]);
                    end
                end
                MODE_NUM:
                begin
                    if (src_byte == CH_SEMI)
                    begin
                        step = STEP_EMIT;
                        dec  = num_dec;
                    end
                    else if (dig_cur[4])
                    begin
                        step   = STEP_HOLD;
                        code_n = code_sat;
                    end
                end
                default:
                begin
                    step = STEP_FAIL;
                end
            endcase
            if (step == STEP_HOLD && count_reg >= CNT_W'(PEND_MAX))
            begin
                step = STEP_FAIL;
            end
        end
    end

    assign ram_we    = cmd.commit && (step == STEP_HOLD);
    assign ram_waddr = text_path ? '0 : count_reg[ADDR_W-1:0];

    always_comb
    begin
        count_next      = count_reg;
        mode_next       = mode_reg;
        hex_next        = hex_reg;
        code_next       = code_reg;
        alive_next      = alive_reg;
        idx_next        = idx_reg;
        flush_last_next = flush_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_last_next  = pend_last_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.capture_pend)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = in_byte;
            pend_last_next  = in_last;
        end

        if (cmd.commit)
        begin
            pend_valid_next = 1'b0;
            if (step == STEP_HOLD)
            begin
                count_next = text_path ? CNT_W'(1) : count_reg + CNT_W'(1);
                mode_next  = mode_n;
                hex_next   = hex_n;
                code_next  = code_n;
                alive_next = alive_n;
            end
            else if (step == STEP_EMIT)
            begin
                count_next     = '0;
                mode_next      = MODE_TEXT;
                hex_next       = 1'b0;
                code_next      = '0;
                out_valid_next = 1'b1;
                out_byte_next  = dec;
                out_last_next  = src_last;
            end
        end

        if (cmd.flush_start)
        begin
            idx_next        = '0;
            flush_last_next = cmd.flush_last;
        end

        if (cmd.flush_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_last_next  = flush_last_reg && flush_final;
            idx_next       = idx_reg + ADDR_W'(1);
        end

        if (cmd.flush_clear)
        begin
            count_next = '0;
            mode_next  = MODE_TEXT;
            hex_next   = 1'b0;
            code_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            mode_reg       <= MODE_TEXT;
            hex_reg        <= 1'b0;
            code_reg       <= '0;
            alive_reg      <= '0;
            idx_reg        <= '0;
            flush_last_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            mode_reg       <= mode_next;
            hex_reg        <= hex_next;
            code_reg       <= code_next;
            alive_reg      <= alive_next;
            idx_reg        <= idx_next;
            flush_last_reg <= flush_last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        pend_byte_reg <= pend_byte_next;
        pend_last_reg <= pend_last_next;
    end

    hed_ram #(
        .WIDTH (8),
        .DEPTH (PEND_MAX)
    ) u_held_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (src_byte),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign stat.step        = step;
    assign stat.last        = src_last;
    assign stat.slot_free   = slot_free;
    assign stat.flush_final = flush_final;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

### hw/rtl/hed_ctrl.sv
module hed_ctrl import hed_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  hed_stat_t stat,
    output hed_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_READ   = 2'd1,
        ST_EMIT   = 2'd2,
        ST_REPLAY = 2'd3
    } state_t;

    state_t state_reg, state_next;
    logic   replay_reg, replay_next;

    always_comb
    begin
        cmd         = '0;
        in_stall    = 1'b1;
        state_next  = state_reg;
        replay_next = replay_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = !stat.slot_free;
                if (in_valid && stat.slot_free)
                begin
                    case (stat.step)
                        STEP_EMIT:
                        begin
                            cmd.commit = 1'b1;
                        end
                        STEP_HOLD:
                        begin
                            cmd.commit = 1'b1;
                            if (stat.last)
                            begin
                                cmd.flush_start = 1'b1;
                                cmd.flush_last  = 1'b1;
                                replay_next     = 1'b0;
                                state_next      = ST_READ;
                            end
                        end
                        default:
                        begin
                            // failed reference: flush held bytes, then replay
                            cmd.capture_pend = 1'b1;
                            cmd.flush_start  = 1'b1;
                            cmd.flush_last   = 1'b0;
                            replay_next      = 1'b1;
                            state_next       = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.flush_emit = 1'b1;
                    if (stat.flush_final)
                    begin
                        cmd.flush_clear = 1'b1;
                        state_next      = replay_reg ? ST_REPLAY : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_REPLAY:
            begin
                if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    if (stat.step == STEP_HOLD && stat.last)
                    begin
                        cmd.flush_start = 1'b1;
                        cmd.flush_last  = 1'b1;
                        replay_next     = 1'b0;
                        state_next      = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            replay_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            replay_reg <= replay_next;
        end
    end

endmodule

### hw/rtl/html_entity_decoder_top.sv
// channel | signals                             | request taken when
// input   | in_valid in_stall in_byte in_last   | in_valid && !in_stall
// output  | out_valid out_stall out_byte out_last | out_valid && !out_stall
//
// plain bytes and completed references go straight to the output register
// held bytes are read through the ram read port and emitted one at a time
// a failed reference replays the failing byte after the flush
// rst_n is asynchronous and clears the scan state and the output valid flag
// input stalls while a flush runs and while the output register is held by out_stall

`include "html_entity_decoder_top_assert.svh"

module html_entity_decoder_top import hed_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    hed_cmd_t  cmd;
    hed_stat_t stat;

    hed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hed_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    `HED_ASSERT_NOW(a_no_overwrite, cmd.commit || cmd.flush_emit, stat.slot_free)
    `HED_ASSERT_NEXT(a_emit_shows, in_valid && !in_stall && stat.step == STEP_EMIT, out_valid)
    `HED_ASSERT_NEXT(a_fail_busy, in_valid && !in_stall && stat.step == STEP_FAIL, in_stall)

endmodule

### verif/tb_top.sv
module tb_top;
    import hed_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int SETTLE      = 2 * PEND_MAX + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_CYCLES  = 1_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_last;

    text_byte_t expected_text[$];
    logic [7:0] run_buf[$];

    // decoder state mirror
    logic [7:0] held_buf[PEND_MAX];
    int         held_len = 0;
    mode_t      scan_st  = MODE_TEXT;
    logic       hex_ref  = 1'b0;
    int         acc_val  = 0;

    string      ent_text[6] = '{"&nbsp;", "&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};
    logic [7:0] ent_code[6] = '{8'h20, 8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    bit         idle_on      = 1'b0;
    bit         hold_req     = 1'b0;
    int         errors       = 0;
    int         bytes_sent   = 0;
    int         runs_sent    = 0;
    int         results_seen = 0;

    html_entity_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * MAX_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void push_decoded(input logic [7:0] b);
        text_byte_t t;
        t.data = b;
        t.last = 1'b0;
        expected_text.push_back(t);
    endfunction

    function automatic void flush_literal();
        for (int i = 0; i < held_len; i++)
            push_decoded(held_buf[i]);
        held_len = 0;
        scan_st  = MODE_TEXT;
        hex_ref  = 1'b0;
        acc_val  = 0;
    endfunction

    function automatic int digit_value(input logic [7:0] b, input logic hex);
        if (b >= CH_0 && b <= CH_9)
            return int'(b - CH_0);
        if (hex && b >= CH_LA && b <= CH_LF)
            return int'(b - CH_LA) + 10;
        if (hex && b >= CH_UA && b <= CH_UF)
            return int'(b - CH_UA) + 10;
        return -1;
    endfunction

    // named entity match on held prefix plus b
    function automatic step_t name_step(input logic [7:0] b, output logic [7:0] dec);
        bit same;
        dec = 8'h00;
        for (int e = 0; e < 6; e++)
        begin
            if (held_len < ent_text[e].len() && ent_text[e][held_len] == b)
            begin
                same = 1'b1;
                for (int i = 0; i < held_len; i++)
                    if (held_buf[i] != ent_text[e][i])
                        same = 1'b0;
                if (same)
                begin
                    if (held_len + 1 == ent_text[e].len())
                    begin
                        dec = ent_code[e];
                        return STEP_EMIT;
                    end
                    return STEP_HOLD;
                end
            end
        end
        return STEP_FAIL;
    endfunction

    function automatic step_t ref_advance(input logic [7:0] b, output logic [7:0] dec,
                                          output mode_t nst, output logic nhex,
                                          output int nacc);
        int d;
        int v;
        nst  = scan_st;
        nhex = hex_ref;
        nacc = acc_val;
        dec  = 8'h00;
        case (scan_st)
            MODE_AMP:
            begin
                if (b == CH_HASH)
                begin
                    nst = MODE_HASH;
                    return STEP_HOLD;
                end
                nst = MODE_NAME;
                return name_step(b, dec);
            end
            MODE_NAME:
                return name_step(b, dec);
            MODE_HASH:
            begin
                if (b == CH_LX || b == CH_UX)
                begin
                    nst  = MODE_NUM;
                    nhex = 1'b1;
                    nacc = 0;
                    return STEP_HOLD;
                end
                if (b == CH_SEMI)
                begin
                    dec = CH_QMARK;
                    return STEP_EMIT;
                end
                d = digit_value(b, 1'b0);
                if (d < 0)
                    return STEP_FAIL;
                nst  = MODE_NUM;
                nhex = 1'b0;
                nacc = d;
                return STEP_HOLD;
            end
            MODE_NUM:
            begin
                if (b == CH_SEMI)
                begin
                    dec = (acc_val >= 1 && acc_val <= 255) ? 8'(acc_val) : CH_QMARK;
                    return STEP_EMIT;
                end
                d = digit_value(b, hex_ref);
                if (d < 0)
                    return STEP_FAIL;
                v = acc_val * (hex_ref ? 16 : 10) + d;
                nacc = (v > int'(CODE_SAT)) ? int'(CODE_SAT) : v;
                return STEP_HOLD;
            end
            default:
                return STEP_FAIL;
        endcase
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int         start_n;
        step_t      act;
        logic [7:0] dec;
        mode_t      nst;
        logic       nhex;
        int         nacc;
        start_n = expected_text.size();
        for (int pass = 0; pass < 2; pass++)
        begin
            if (scan_st == MODE_TEXT || held_len == 0)
            begin
                held_len = 0;
                if (b == CH_AMP)
                begin
                    held_buf[0] = b;
                    held_len    = 1;
                    scan_st     = MODE_AMP;
                    hex_ref     = 1'b0;
                    acc_val     = 0;
                end
                else
                begin
                    scan_st = MODE_TEXT;
                    push_decoded(b);
                end
                break;
            end
            act = ref_advance(b, dec, nst, nhex, nacc);
            if (act == STEP_HOLD && held_len >= PEND_MAX)
                act = STEP_FAIL;
            if (act == STEP_HOLD)
            begin
                held_buf[held_len] = b;
                held_len++;
                scan_st = nst;
                hex_ref = nhex;
                acc_val = nacc;
                break;
            end
            if (act == STEP_EMIT)
            begin
                held_len = 0;
                scan_st  = MODE_TEXT;
                hex_ref  = 1'b0;
                acc_val  = 0;
                push_decoded(dec);
                break;
            end
            // failing byte goes round again in text mode
            flush_literal();
        end
        if (last)
        begin
            flush_literal();
            if (expected_text.size() > start_n)
                expected_text[expected_text.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            run_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_digit(input logic hex, input bit lean_zero);
        string digs = "0123456789abcdefABCDEF";
        if (lean_zero && $urandom_range(0, 3) != 0)
            return CH_0;
        return digs[$urandom_range(0, hex ? 21 : 9)];
    endfunction

    function automatic void add_numeric(input logic hex, input int ndig, input bit close,
                                        input bit lean_zero);
        run_buf.push_back(CH_AMP);
        run_buf.push_back(CH_HASH);
        if (hex)
            run_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        repeat (ndig)
            run_buf.push_back(rand_digit(hex, lean_zero));
        if (close)
            run_buf.push_back(CH_SEMI);
    endfunction

    function automatic void add_token();
        int  kind;
        int  n;
        int  p;
        string pick;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1, 2:
                run_buf.push_back(8'($urandom_range(0, 255)));
            3, 4:
                add_str(ent_text[$urandom_range(0, 5)]);
            5:
                add_numeric(1'b0, $urandom_range(0, 4), $urandom_range(0, 5) != 0, 1'b0);
            6:
                add_numeric(1'b1, $urandom_range(0, 3), $urandom_range(0, 5) != 0, 1'b0);
            7:
            begin
                // entity with one byte corrupted
                pick = ent_text[$urandom_range(0, 5)];
                add_str(pick);
                p = run_buf.size() - $urandom_range(1, pick.len() - 1);
                run_buf[p] = 8'($urandom_range(0, 255));
            end
            8:
            begin
                // truncated entity followed by anything
                pick = ent_text[$urandom_range(0, 5)];
                n = $urandom_range(1, pick.len() - 1);
                for (int i = 0; i < n; i++)
                    run_buf.push_back(pick[i]);
                run_buf.push_back(8'($urandom_range(0, 255)));
            end
            9:
                add_numeric(1'($urandom_range(0, 1)),
                            $urandom_range(PEND_MAX - 5, PEND_MAX + 1),
                            $urandom_range(0, 3) != 0, 1'b1);
            10:
            begin
                run_buf.push_back(CH_AMP);
                if ($urandom_range(0, 1))
                    run_buf.push_back(CH_AMP);
                else
                    run_buf.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: add_str("&#0;");
                    1: add_str("&#256;");
                    2: add_str("&#x0;");
                    3: add_str("&#XfF;");
                    4: add_str("&#1;");
                    default: add_str("&#x100;");
                endcase
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_run();
        for (int i = 0; i < run_buf.size(); i++)
            send_byte(run_buf[i], i == run_buf.size() - 1);
        run_buf.delete();
        runs_sent++;
    endtask

    task automatic send_random_run();
        repeat ($urandom_range(1, 8))
            add_token();
        send_run();
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_directed();
        run_buf.push_back(8'h00);
        add_str("&amp;&#;&#x;&#999;");
        run_buf.push_back(8'hFF);
        send_run();
        // reference still open at end of run
        add_str("&q");
        send_run();
    endtask

    task automatic test_named_entities();
        for (int e = 0; e < 6; e++)
        begin
            add_str(ent_text[e]);
            run_buf.push_back(8'($urandom_range(0, 255)));
        end
        send_run();
    endtask

    task automatic test_overlong_refs();
        logic hex;
        int   ndig;
        for (int k = 0; k < 6; k++)
        begin
            hex  = 1'(k % 2);
            ndig = PEND_MAX - (hex ? 3 : 2) + (k / 2 - 1);
            add_numeric(hex, ndig, 1'b1, 1'b1);
            send_run();
        end
        wait_drain();
    endtask

    task automatic test_output_hold();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            add_numeric(1'b0, PEND_MAX - 1, 1'b1, 1'b0);
            add_token();
            send_run();
        end
        wait_drain();
    endtask

    task automatic test_random_runs();
        while (bytes_sent < 240)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_run();
        end
        wait_drain();
    endtask

    task automatic test_no_idle_tail();
        int target;
        target  = bytes_sent + 60;
        idle_on = 1'b0;
        while (bytes_sent < target)
            send_random_run();
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        text_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected out_byte 0x%02h out_last %0b",
                         $time, out_byte, out_last);
                errors++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected 0x%02h actual 0x%02h",
                             $time, want.data, out_byte);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.last, out_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        in_last  <= 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_named_entities();
        test_overlong_refs();
        test_output_hold();
        test_random_runs();
        test_no_idle_tail();
        wait_drain();

        if (expected_text.size() != 0)
        begin
            $display("%0t: %0d decoded bytes never arrived", $time, expected_text.size());
            errors++;
        end
        $display("decoded %0d input bytes in %0d runs into %0d checked output bytes",
                 bytes_sent, runs_sent, results_seen);
        $display("named, numeric, broken and overlong references under random stalls");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### html_entity_decoder_top.f
+incdir+hw/rtl
hw/rtl/hed_pkg.sv
hw/rtl/hed_ram.sv
hw/rtl/hed_datapath.sv
hw/rtl/hed_ctrl.sv
hw/rtl/html_entity_decoder_top.sv
verif/tb_top.sv
